/* hw/rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int CHAR_W    = 8;
    localparam int SEXTET_W  = 6;
    localparam int MAX_CHARS = 4;
    localparam int IDX_W     = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [SEXTET_W-1:0] SEX_LOWER = 6'd26;
    localparam logic [SEXTET_W-1:0] SEX_DIGIT = 6'd52;
    localparam logic [SEXTET_W-1:0] SEX_PLUS  = 6'd62;

    typedef logic [CHAR_W-1:0] t_char;

    // characters produced by one byte, sent by the back end one per cycle unless the output stalls
    typedef struct packed {
        t_char [MAX_CHARS-1:0] chars;
        logic  [IDX_W-1:0]     last_idx;
        logic                  is_final;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_char b64_char(input logic [SEXTET_W-1:0] s);
        t_char c;
        priority if (s < SEX_LOWER) begin
            c = CHAR_UPPER + {2'b00, s};
        end else if (s < SEX_DIGIT) begin
            c = CHAR_LOWER + {2'b00, s - SEX_LOWER};
        end else if (s < SEX_PLUS) begin
            c = CHAR_DIGIT + {2'b00, s - SEX_DIGIT};
        end else if (s == SEX_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group phase and leftover bits, and builds
// the list of characters that each byte produces.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_final_byte,
    input  b64e_pkg::t_q_stat i_q_stat,
    output logic              o_stall,
    output logic              o_push,
    output b64e_pkg::t_job    o_job
);
    import b64e_pkg::*;

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic       accept;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign o_push  = accept;

    always_comb begin
        o_job          = '0;
        o_job.is_final = i_final_byte;
        n_phase        = r_phase;
        n_carry        = r_carry;
        case (r_phase)
            PH1: begin
                o_job.chars[0] = b64_char({r_carry[1:0], i_data_byte[7:4]});
                n_carry        = i_data_byte[3:0];
                n_phase        = PH2;
                if (i_final_byte) begin
                    o_job.chars[1] = b64_char({i_data_byte[3:0], 2'b00});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.last_idx = 2'd2;
                end
            end
            PH2: begin
                o_job.chars[0] = b64_char({r_carry, i_data_byte[7:6]});
                o_job.chars[1] = b64_char(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
                n_carry        = 4'd0;
                n_phase        = PH0;
            end
            default: begin
                o_job.chars[0] = b64_char(i_data_byte[7:2]);
                n_carry        = {2'b00, i_data_byte[1:0]};
                n_phase        = PH1;
                if (i_final_byte) begin
                    o_job.chars[1] = b64_char({i_data_byte[1:0], 4'b0000});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.chars[3] = PAD_CHAR;
                    o_job.last_idx = 2'd3;
                end
            end
        endcase
        if (i_final_byte) begin
            n_phase = PH0;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_carry <= 4'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

    // group restarts after a final byte
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final_byte) |=> (r_phase == PH0 && r_carry == 4'd0))
        else $error("group not restarted after final byte");

    // the carry holds only two bits going into the second byte of a group
    a_carry_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH1) |-> (r_carry[3:2] == 2'b00))
        else $error("stale carry bits in phase one");

    // the third byte of a group returns to the start
    a_phase_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH2) |=> (r_phase == PH0 && r_carry == 4'd0))
        else $error("phase did not wrap after third byte");

endmodule

/* hw/rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of character jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_job    i_job,
    input  logic              i_pop,
    output b64e_pkg::t_job    o_head,
    output b64e_pkg::t_q_stat o_q_stat
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == CNT_FULL);
    assign o_q_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Steps through the head job one character per cycle while the output is
// not stalled, into the output register, and pops the job as its last character loads.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64e_pkg::t_job    i_head,
    input  b64e_pkg::t_q_stat i_q_stat,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output logic [7:0]        o_out_char,
    output logic              o_last_char
);
    import b64e_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_char            r_char;
    logic             r_last;
    logic             load;
    logic             at_end;

    assign load   = !i_q_stat.empty && (!r_valid || !i_stall);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_last <= i_head.is_final && at_end;
        end
    end

    // no partly sent job remains once the queue drains
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> (r_idx == '0))
        else $error("character index left mid-job");

    // only the closing character of a job can carry the end mark
    a_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !at_end) |=> (r_valid && !r_last))
        else $error("end mark on inner character");

    // a held output word freezes the job position
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> $stable(r_idx))
        else $error("index moved under stall");

endmodule

/* hw/rtl/base64_encoder.sv */
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
//
//   channel  direction  handshake           word
//   input    in         i_valid / o_stall   i_data_byte, i_final_byte
//   output   out        o_valid / i_stall   o_out_char, o_last_char
//
// one character leaves per cycle from the output register while a job waits and
// i_stall is low; a byte yields one to four characters, a full group of three yields four.
// the front takes a byte every cycle while the job queue has room.
// the first character of a byte passes through the job queue and then the output register.
// i_rst_n is synchronous; after reset the encoder starts a new group.
// o_stall rises only when the job queue is full.
// ----------------------------------------------------------------------------
module base64_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);
    import b64e_pkg::*;

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_stat     (q_stat),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_q_stat (q_stat)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q_stat    (q_stat),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

/* tb/tb_base64_encoder.sv */
// ----------------------------------------------------------------------------
// tb_base64_encoder
// Self-checking bench for the streaming base64 encoder. Whole messages of
// raw bytes go in on the input channel. A character model in the checker
// class works out the base64 characters and the last-character flag for
// each byte taken, and compares them in order with the words the encoder
// sends. The bench runs directed corner messages first, then random
// messages under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------

typedef struct packed {
    b64e_pkg::t_char ch;
    logic            last;
} b64_word_t;

class b64_char_checker;

    string       alphabet;
    logic [1:0]  group_pos;
    logic [3:0]  leftover;
    b64_word_t   exp_words[$];
    int          fail_count;

    function new();
        alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        group_pos  = 2'd0;
        leftover   = 4'd0;
        fail_count = 0;
    endfunction

    function b64e_pkg::t_char sextet_to_char(input logic [5:0] s);
        return b64e_pkg::t_char'(alphabet[s]);
    endfunction

    function void push_word(input b64e_pkg::t_char c, input logic l);
        b64_word_t w;
        w.ch   = c;
        w.last = l;
        exp_words.push_back(w);
    endfunction

    function void note_byte(input logic [7:0] b, input logic fin);
        case (group_pos)
            2'd1: begin
                push_word(sextet_to_char({leftover[1:0], b[7:4]}), 1'b0);
                leftover  = b[3:0];
                group_pos = 2'd2;
                if (fin) begin
                    push_word(sextet_to_char({leftover, 2'b00}), 1'b0);
                    push_word(b64e_pkg::PAD_CHAR, 1'b1);
                end
            end
            2'd2: begin
                push_word(sextet_to_char({leftover, b[7:6]}), 1'b0);
                push_word(sextet_to_char(b[5:0]), fin);
                leftover  = 4'd0;
                group_pos = 2'd0;
            end
            default: begin
                push_word(sextet_to_char(b[7:2]), 1'b0);
                leftover  = {2'b00, b[1:0]};
                group_pos = 2'd1;
                if (fin) begin
                    push_word(sextet_to_char({leftover[1:0], 4'b0000}), 1'b0);
                    push_word(b64e_pkg::PAD_CHAR, 1'b0);
                    push_word(b64e_pkg::PAD_CHAR, 1'b1);
                end
            end
        endcase
        if (fin) begin
            group_pos = 2'd0;
            leftover  = 4'd0;
        end
    endfunction

    function void check_char(input b64e_pkg::t_char c, input logic l);
        b64_word_t w;
        if (exp_words.size() == 0) begin
            $display("%0t: unexpected word char %h last %b", $time, c, l);
            fail_count++;
            return;
        end
        w = exp_words.pop_front();
        if (c !== w.ch) begin
            $display("%0t: out_char mismatch expected %h actual %h", $time, w.ch, c);
            fail_count++;
        end
        if (l !== w.last) begin
            $display("%0t: last_char mismatch expected %b actual %b", $time, w.last, l);
            fail_count++;
        end
    endfunction

    function int pending();
        return exp_words.size();
    endfunction

endclass

module tb_base64_encoder;

    localparam int STUCK_LIMIT = 2000;
    localparam int N_DIRECTED  = 20;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_last_char;

    int send_idle_pct = 21;
    int recv_idle_pct = 69;
    int stuck_cycles  = 0;

    b64_char_checker sb;

    base64_encoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    always #6 i_clk = ~i_clk;

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, fin);
        @(negedge i_clk);
    endtask

    task automatic send_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(40, 10);
            end else begin
                len = $urandom_range(9, 1);
            end
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(255)), k == len - 1);
            end
            sent += len;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char(o_out_char, o_last_char);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        // final byte at each group position, all-zero and all-one bytes,
        // a group of '+' and a group of '/'
        logic [7:0] dir_bytes [N_DIRECTED] = '{
            8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF,
            8'hFF, 8'h00, 8'h00, 8'h00, 8'h4D, 8'h61, 8'h6E, 8'hFB,
            8'hEF, 8'hBE, 8'h01, 8'h02
        };
        logic dir_fin [N_DIRECTED] = '{
            1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
            1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
            1'b0, 1'b0, 1'b0, 1'b1
        };

        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_byte(dir_bytes[k], dir_fin[k]);
        end
        send_messages(140);

        send_idle_pct = 69;
        recv_idle_pct = 21;
        send_messages(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_messages(160);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
